@@ hdl/bre_pkg.sv @@
// Shared types and constants for the byte relative encoder.
`timescale 1ns / 1ps

package bre_pkg;

    localparam int WORD_W = 32;
    localparam int BYTE_W = 8;
    localparam int CAP_W  = 31;

    localparam logic [CAP_W-1:0] CAP_RESET = {CAP_W{1'b1}};

    // Both words must lie within this magnitude for a delta byte.
    localparam logic signed [WORD_W-1:0] LIMIT_POS = 32'sd1073741824;
    localparam logic signed [WORD_W-1:0] LIMIT_NEG = -32'sd1073741824;
    localparam logic signed [WORD_W-1:0] DELTA_MAX = 32'sd127;
    localparam logic signed [WORD_W-1:0] DELTA_MIN = -32'sd127;

    localparam logic [BYTE_W-1:0] ESCAPE_BYTE = 8'h80;

    // Bytes that a delta item and an escaped item add to the running count.
    localparam logic [WORD_W-1:0] DELTA_COST  = 32'd1;
    localparam logic [WORD_W-1:0] ESCAPE_COST = 32'd5;

    // Byte slot of an escaped item: marker first, then four word bytes.
    localparam int IDX_W = 3;
    localparam logic [IDX_W-1:0] IDX_MARKER = 3'd0;
    localparam logic [IDX_W-1:0] IDX_BYTE0  = 3'd1;
    localparam logic [IDX_W-1:0] IDX_BYTE1  = 3'd2;
    localparam logic [IDX_W-1:0] IDX_BYTE2  = 3'd3;
    localparam logic [IDX_W-1:0] IDX_BYTE3  = 3'd4;

    // Command queue between front and back.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    typedef enum logic [1:0] {
        CMD_DELTA,
        CMD_ESCAPE,
        CMD_OVERFLOW
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [WORD_W-1:0]   data;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

@@ hdl/bre_front.sv @@
// Front end: accepts words, classifies them and tracks the block state.
`timescale 1ns / 1ps

module bre_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bre_pkg::CAP_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bre_pkg::WORD_W-1:0]    s_tdata,
    input  logic                          s_tlast,
    input  bre_pkg::fifo_status_t         fifo_status,
    output logic                          push,
    output bre_pkg::cmd_t                 push_cmd
);

    logic [bre_pkg::CAP_W-1:0]         cap_reg;
    logic [bre_pkg::WORD_W-1:0]        prev_reg;
    logic [bre_pkg::WORD_W-1:0]        prev_next;
    logic [bre_pkg::CAP_W-1:0]         count_reg;
    logic [bre_pkg::CAP_W-1:0]         count_next;
    logic                              ovf_seen_reg;
    logic                              ovf_seen_next;

    logic signed [bre_pkg::WORD_W-1:0] word;
    logic signed [bre_pkg::WORD_W-1:0] prev;
    logic signed [bre_pkg::WORD_W-1:0] delta;
    logic                              in_range;
    logic                              fits_byte;
    logic [bre_pkg::WORD_W-1:0]        need;
    logic                              overflow;
    logic                              accept;

    // Accept whenever the command queue has room.
    assign s_tready = !fifo_status.full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept;

    // Classify the word against the previous one.
    always_comb
    begin
        word      = signed'(s_tdata);
        prev      = signed'(prev_reg);
        delta     = word - prev;
        in_range  = (word <= bre_pkg::LIMIT_POS) && (word >= bre_pkg::LIMIT_NEG) &&
                    (prev <= bre_pkg::LIMIT_POS) && (prev >= bre_pkg::LIMIT_NEG);
        fits_byte = in_range && (delta <= bre_pkg::DELTA_MAX) &&
                    (delta >= bre_pkg::DELTA_MIN);
        need      = {1'b0, count_reg} +
                    (fits_byte ? bre_pkg::DELTA_COST : bre_pkg::ESCAPE_COST);
        overflow  = ovf_seen_reg || (need > {1'b0, cap_reg});
    end

    // Command for the back end.
    always_comb
    begin
        if (overflow)
        begin
            push_cmd.kind = bre_pkg::CMD_OVERFLOW;
            push_cmd.data = '0;
        end
        else if (fits_byte)
        begin
            push_cmd.kind = bre_pkg::CMD_DELTA;
            push_cmd.data = {{(bre_pkg::WORD_W-bre_pkg::BYTE_W){1'b0}},
                             delta[bre_pkg::BYTE_W-1:0]};
        end
        else
        begin
            push_cmd.kind = bre_pkg::CMD_ESCAPE;
            push_cmd.data = s_tdata;
        end
    end

    // Block state update; the count never passes the capacity, so it fits.
    always_comb
    begin
        prev_next     = prev_reg;
        count_next    = count_reg;
        ovf_seen_next = ovf_seen_reg;
        if (accept)
        begin
            if (overflow)
            begin
                ovf_seen_next = 1'b1;
            end
            else
            begin
                prev_next  = s_tdata;
                count_next = need[bre_pkg::CAP_W-1:0];
            end
            if (s_tlast)
            begin
                prev_next     = '0;
                count_next    = '0;
                ovf_seen_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg      <= bre_pkg::CAP_RESET;
            prev_reg     <= '0;
            count_reg    <= '0;
            ovf_seen_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            prev_reg     <= prev_next;
            count_reg    <= count_next;
            ovf_seen_reg <= ovf_seen_next;
        end
    end

endmodule

@@ hdl/bre_cmd_fifo.sv @@
// Short command queue between the front and back ends.
`timescale 1ns / 1ps

module bre_cmd_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  bre_pkg::cmd_t          push_cmd,
    input  logic                   pop,
    output bre_pkg::cmd_t          head_cmd,
    output bre_pkg::fifo_status_t  status
);

    bre_pkg::cmd_t                 entries [bre_pkg::FIFO_DEPTH];
    logic [bre_pkg::FIFO_AW-1:0]   wr_ptr_reg;
    logic [bre_pkg::FIFO_AW-1:0]   wr_ptr_next;
    logic [bre_pkg::FIFO_AW-1:0]   rd_ptr_reg;
    logic [bre_pkg::FIFO_AW-1:0]   rd_ptr_next;
    logic [bre_pkg::FIFO_CW-1:0]   count_reg;
    logic [bre_pkg::FIFO_CW-1:0]   count_next;

    assign status.full  = (count_reg == bre_pkg::FIFO_CW'(bre_pkg::FIFO_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_cmd     = entries[rd_ptr_reg];

    // Pointer and fill level update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ hdl/bre_back.sv @@
// Back end: expands queued commands into output bytes.
`timescale 1ns / 1ps

module bre_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bre_pkg::cmd_t                head_cmd,
    input  bre_pkg::fifo_status_t        fifo_status,
    output logic                         pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [bre_pkg::BYTE_W-1:0]   m_tdata,
    output logic                         m_tlast,
    output logic                         m_tuser
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [bre_pkg::BYTE_W-1:0]    byte_reg;
    logic [bre_pkg::BYTE_W-1:0]    byte_next;
    logic                          last_reg;
    logic                          last_next;
    logic                          ovf_reg;
    logic                          ovf_next;
    logic [bre_pkg::IDX_W-1:0]     idx_reg;
    logic [bre_pkg::IDX_W-1:0]     idx_next;
    logic                          load;
    logic                          final_byte;

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = ovf_reg;

    // The output register takes a new byte when empty or being drained.
    assign load = !valid_reg || m_tready;

    // Pick the byte for the head command at the current slot.
    always_comb
    begin
        byte_next  = '0;
        ovf_next   = 1'b0;
        final_byte = 1'b1;
        unique case (head_cmd.kind)
            bre_pkg::CMD_DELTA:
            begin
                byte_next = head_cmd.data[bre_pkg::BYTE_W-1:0];
            end
            bre_pkg::CMD_OVERFLOW:
            begin
                ovf_next = 1'b1;
            end
            bre_pkg::CMD_ESCAPE:
            begin
                final_byte = (idx_reg == bre_pkg::IDX_BYTE3);
                unique case (idx_reg)
                    bre_pkg::IDX_MARKER: byte_next = bre_pkg::ESCAPE_BYTE;
                    bre_pkg::IDX_BYTE0:  byte_next = head_cmd.data[7:0];
                    bre_pkg::IDX_BYTE1:  byte_next = head_cmd.data[15:8];
                    bre_pkg::IDX_BYTE2:  byte_next = head_cmd.data[23:16];
                    bre_pkg::IDX_BYTE3:  byte_next = head_cmd.data[31:24];
                    default:             byte_next = '0;
                endcase
            end
            default:
            begin
                byte_next = '0;
            end
        endcase
        last_next = final_byte;
    end

    // Slot counter and queue pop.
    always_comb
    begin
        pop        = 1'b0;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = !fifo_status.empty;
            if (!fifo_status.empty)
            begin
                if (final_byte)
                begin
                    pop      = 1'b1;
                    idx_next = bre_pkg::IDX_MARKER;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= bre_pkg::IDX_MARKER;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Output payload holds while stalled.
    always_ff @(posedge clk)
    begin
        if (load && !fifo_status.empty)
        begin
            byte_reg <= byte_next;
            last_reg <= last_next;
            ovf_reg  <= ovf_next;
        end
    end

endmodule

@@ hdl/byte_relative_encoder.sv @@
// Top level of the byte relative encoder.
// The first byte of an item passes through the command queue and the output register before it is valid.
// Throughput: one item per cycle for delta and overflow items while m_tready holds high; an escaped
// item is sent as five bytes through the single-byte output port of the back end.
// Reset: rst_n clears the block state, the queue and the output; capacity returns
// to its maximum.
`timescale 1ns / 1ps

module byte_relative_encoder (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [bre_pkg::CAP_W-1:0]    cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [bre_pkg::WORD_W-1:0]   s_tdata,   // [31:0] word_value
    input  logic                         s_tlast,   // last_word
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [bre_pkg::BYTE_W-1:0]   m_tdata,   // [7:0] out_byte
    output logic                         m_tlast,   // item_done
    output logic                         m_tuser    // [0] overflow
);

    logic                  push;
    logic                  pop;
    bre_pkg::cmd_t         push_cmd;
    bre_pkg::cmd_t         head_cmd;
    bre_pkg::fifo_status_t fifo_status;

    bre_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .fifo_status (fifo_status),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    bre_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (fifo_status)
    );

    bre_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_cmd    (head_cmd),
        .fifo_status (fifo_status),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    // The front never writes into a full queue.
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !fifo_status.full)
        else $error("command pushed into a full queue");

    // The back never pops an empty queue.
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !fifo_status.empty)
        else $error("command popped from an empty queue");

    // An overflow result is a single zero byte that ends its item.
    a_overflow_form: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == '0)))
        else $error("malformed overflow result");

    // A popped command leaves the queue with room for the front.
    a_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> !fifo_status.full)
        else $error("queue still full after a pop");

endmodule

@@ tb/sv/tb_byte_relative_encoder.sv @@
// Self-checking testbench for the byte relative encoder.
`timescale 1ns / 1ps

module tb_byte_relative_encoder;

    // Range limit of both words for a delta byte, and the delta bounds.
    localparam int     WORD_LIMIT   = 1073741824;
    localparam int     DELTA_HI     = 127;
    localparam int     DELTA_LO     = -127;
    localparam logic [bre_pkg::BYTE_W-1:0] MARKER_BYTE = 8'h80;
    localparam logic [bre_pkg::CAP_W-1:0]  CAP_MAX     = {bre_pkg::CAP_W{1'b1}};
    localparam int     SETTLE_CYCLES  = 12;
    localparam int     STALL_LIMIT    = 4000;
    localparam int     HOLDOFF_CYCLES = 300;

    typedef enum logic [1:0] {
        FLOW_FREE,
        FLOW_SRC_IDLE,
        FLOW_SNK_STALL,
        FLOW_BOTH
    } flow_mode_t;

    typedef struct {
        logic [bre_pkg::WORD_W-1:0] word;
        logic                       last;
    } word_item_t;

    typedef struct {
        logic [bre_pkg::BYTE_W-1:0] code;
        logic                       done;
        logic                       ovf;
    } byte_item_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    logic [bre_pkg::CAP_W-1:0]    cfg_wdata;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [bre_pkg::WORD_W-1:0]   s_tdata;
    logic                         s_tlast;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [bre_pkg::BYTE_W-1:0]   m_tdata;
    logic                         m_tlast;
    logic                         m_tuser;

    word_item_t          words_pending[$];
    byte_item_t          bytes_expected[$];
    flow_mode_t          flow_mode;
    int                  fails;
    int                  holdoff_left;
    int                  stall_count;
    logic                word_taken;

    // Encoder state as predicted by the testbench.
    logic [bre_pkg::WORD_W-1:0]   last_coded_word;
    logic [bre_pkg::WORD_W-1:0]   block_bytes;
    logic                         block_overflowed;
    logic [bre_pkg::CAP_W-1:0]    capacity_model;

    byte_relative_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // Clock with a 2 ns period.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Predict the bytes that one accepted word produces and update the state.
    task automatic encode_word(input logic [bre_pkg::WORD_W-1:0] word_bits,
                               input logic last);
        int         cur;
        int         prev;
        longint     delta;
        longint     need;
        bit         fits;
        byte_item_t r;
        begin
            cur   = $signed(word_bits);
            prev  = $signed(last_coded_word);
            fits  = 1'b0;
            delta = 0;
            if (cur <= WORD_LIMIT && cur >= -WORD_LIMIT &&
                prev <= WORD_LIMIT && prev >= -WORD_LIMIT)
            begin
                delta = longint'(cur) - longint'(prev);
                fits  = (delta <= DELTA_HI) && (delta >= DELTA_LO);
            end
            need = longint'(block_bytes) + (fits ? 1 : 5);

            if (block_overflowed || need > longint'(capacity_model))
            begin
                block_overflowed = 1'b1;
                r.code = '0;
                r.done = 1'b1;
                r.ovf  = 1'b1;
                bytes_expected.push_back(r);
            end
            else
            begin
                r.ovf = 1'b0;
                if (fits)
                begin
                    r.code = delta[7:0];
                    r.done = 1'b1;
                    bytes_expected.push_back(r);
                end
                else
                begin
                    r.done = 1'b0;
                    r.code = MARKER_BYTE;
                    bytes_expected.push_back(r);
                    for (int k = 0; k < 4; k++)
                    begin
                        r.code = word_bits[8*k +: 8];
                        r.done = (k == 3);
                        bytes_expected.push_back(r);
                    end
                end
                block_bytes     = need[bre_pkg::WORD_W-1:0];
                last_coded_word = word_bits;
            end

            // The end of a block clears the state whether or not it overflowed.
            if (last)
            begin
                last_coded_word  = '0;
                block_bytes      = '0;
                block_overflowed = 1'b0;
            end
        end
    endtask

    // Monitor: register writes, input transfers and output transfers at the rising edge.
    always @(posedge clk)
    begin
        word_taken <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                capacity_model = cfg_wdata;
            end
            if (s_tvalid && s_tready)
            begin
                encode_word(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready)
            begin
                if (bytes_expected.size() == 0)
                begin
                    $display("%0t: unexpected transfer: byte %02h done %0b ovf %0b",
                             $time, m_tdata, m_tlast, m_tuser);
                    fails++;
                end
                else if (bytes_expected[0].code !== m_tdata ||
                         bytes_expected[0].done !== m_tlast ||
                         bytes_expected[0].ovf !== m_tuser)
                begin
                    $display("%0t: expected byte %02h done %0b ovf %0b, got %02h %0b %0b",
                             $time, bytes_expected[0].code, bytes_expected[0].done,
                             bytes_expected[0].ovf, m_tdata, m_tlast, m_tuser);
                    fails++;
                    void'(bytes_expected.pop_front());
                end
                else
                begin
                    void'(bytes_expected.pop_front());
                end
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
        begin
            stall_count <= 0;
        end
        else if (stall_count >= STALL_LIMIT)
        begin
            $display("%0t: timeout with %0d bytes outstanding", $time, bytes_expected.size());
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            stall_count <= stall_count + 1;
        end
    end

    // Driver: offers the next pending word once the current one is taken.
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || word_taken))
        begin
            if (words_pending.size() > 0 &&
                !((flow_mode == FLOW_SRC_IDLE || flow_mode == FLOW_BOTH) &&
                  ($urandom_range(0, 99) < ((flow_mode == FLOW_BOTH) ? 29 : 63))))
            begin
                s_tdata  <= words_pending[0].word;
                s_tlast  <= words_pending[0].last;
                s_tvalid <= 1'b1;
                void'(words_pending.pop_front());
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure and the long hold-off.
    always @(negedge clk)
    begin
        if (holdoff_left > 0)
        begin
            holdoff_left <= holdoff_left - 1;
            m_tready     <= 1'b0;
        end
        else if (flow_mode == FLOW_SNK_STALL)
        begin
            m_tready <= ($urandom_range(0, 99) >= 63);
        end
        else if (flow_mode == FLOW_BOTH)
        begin
            m_tready <= ($urandom_range(0, 99) >= 29);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    task automatic queue_word(input logic [bre_pkg::WORD_W-1:0] word, input logic last);
        word_item_t it;
        begin
            it.word = word;
            it.last = last;
            words_pending.push_back(it);
        end
    endtask

    // Wait until every word is taken and every byte is out, then let the block settle.
    task automatic wait_drained();
        begin
            while (words_pending.size() != 0 || s_tvalid || bytes_expected.size() != 0)
            begin
                @(posedge clk);
            end
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_capacity(input logic [bre_pkg::CAP_W-1:0] value);
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= value;
            @(negedge clk);
            cfg_we    <= 1'b0;
        end
    endtask

    // Random blocks: mostly small deltas from the previous word, with escapes,
    // range-limit words, extremes and a few stray block ends mixed in.
    task automatic queue_random_words(input int count);
        int                prev;
        int                cur;
        int                block_left;
        int                pick;
        logic              last;
        begin
            prev       = 0;
            block_left = $urandom_range(1, 20);
            for (int n = 0; n < count; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                begin
                    cur = prev + $signed($urandom_range(0, 254)) - 127;
                end
                else if (pick < 75)
                begin
                    case ($urandom_range(0, 5))
                        0: cur = WORD_LIMIT;
                        1: cur = -WORD_LIMIT;
                        2: cur = WORD_LIMIT + 1;
                        3: cur = -WORD_LIMIT - 1;
                        4: cur = WORD_LIMIT - $urandom_range(0, 127);
                        default: cur = -WORD_LIMIT + $urandom_range(0, 127);
                    endcase
                end
                else if (pick < 87)
                begin
                    cur = $urandom;
                end
                else if (pick < 94)
                begin
                    cur = ($urandom_range(0, 1) != 0) ? prev + 128 : prev - 128;
                end
                else
                begin
                    cur = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
                end

                block_left--;
                last = (block_left <= 0) || (n == count - 1) || ($urandom_range(0, 99) < 3);
                queue_word(cur, last);
                prev = cur;
                if (last)
                begin
                    prev       = 0;
                    block_left = $urandom_range(1, 20);
                end
            end
        end
    endtask

    // Stimulus sequence and final verdict.
    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        s_tlast          = 1'b0;
        m_tready         = 1'b0;
        word_taken       = 1'b0;
        flow_mode        = FLOW_FREE;
        fails            = 0;
        holdoff_left     = 0;
        stall_count      = 0;
        last_coded_word  = '0;
        block_bytes      = '0;
        block_overflowed = 1'b0;
        capacity_model   = CAP_MAX;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Delta bounds, escapes and the range limit at the reset capacity.
        queue_word(32'd0, 1'b0);
        queue_word(32'd127, 1'b0);
        queue_word(32'd0, 1'b0);
        queue_word(-32'sd128, 1'b0);
        queue_word(-32'sd1, 1'b0);
        queue_word(WORD_LIMIT, 1'b0);
        queue_word(WORD_LIMIT - 127, 1'b0);
        queue_word(WORD_LIMIT, 1'b0);
        queue_word(WORD_LIMIT + 1, 1'b0);
        queue_word(WORD_LIMIT, 1'b0);
        queue_word(-WORD_LIMIT, 1'b0);
        queue_word(-WORD_LIMIT + 1, 1'b0);
        queue_word(32'h7FFF_FFFF, 1'b1);
        queue_word(32'd5, 1'b0);
        queue_word(32'h8000_0000, 1'b1);
        queue_word(32'd0, 1'b1);
        wait_drained();

        // Capacity reached exactly, then overflow, sticky overflow and the block end.
        write_capacity(31'd6);
        queue_word(32'd200, 1'b0);
        queue_word(32'd201, 1'b0);
        queue_word(32'd202, 1'b0);
        queue_word(32'd203, 1'b0);
        queue_word(32'd204, 1'b1);
        queue_word(32'd3, 1'b0);
        queue_word(32'd0, 1'b1);
        wait_drained();

        // Zero capacity overflows every word.
        write_capacity(31'd0);
        queue_word(32'd1, 1'b0);
        queue_word(32'd2, 1'b1);
        wait_drained();

        // Room for one delta byte but not for an escaped word.
        write_capacity(31'd1);
        queue_word(32'd9, 1'b0);
        queue_word(32'd300, 1'b1);
        wait_drained();

        // Random phases under each flow pattern.
        write_capacity(CAP_MAX);
        flow_mode = FLOW_FREE;
        queue_random_words(110);
        wait_drained();

        write_capacity(bre_pkg::CAP_W'($urandom_range(10, 80)));
        flow_mode = FLOW_SRC_IDLE;
        queue_random_words(90);
        wait_drained();

        write_capacity(bre_pkg::CAP_W'($urandom_range(30, 200)));
        flow_mode = FLOW_SNK_STALL;
        queue_random_words(90);
        wait_drained();

        write_capacity(bre_pkg::CAP_W'($urandom_range(1, 120)));
        flow_mode = FLOW_BOTH;
        queue_random_words(90);
        wait_drained();

        // Long receiver hold-off while the sender keeps offering words.
        write_capacity(CAP_MAX);
        flow_mode = FLOW_FREE;
        @(posedge clk);
        holdoff_left = HOLDOFF_CYCLES;
        queue_random_words(60);
        wait_drained();

        if (fails == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ byte_relative_encoder.f @@
hdl/bre_pkg.sv
hdl/bre_front.sv
hdl/bre_cmd_fifo.sv
hdl/bre_back.sv
hdl/byte_relative_encoder.sv
tb/sv/tb_byte_relative_encoder.sv
